>>> src/quoted_string_escape_decoder_unit_assert.svh
// Assertion macros for the quoted string escape decoder.
// Used by the top level only; needs nothing else.
`ifndef QUOTED_STRING_ESCAPE_DECODER_UNIT_ASSERT_SVH
`define QUOTED_STRING_ESCAPE_DECODER_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define QSED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define QSED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/qsed_pkg.sv
// Shared types, codes and helper functions of the quoted string escape decoder.
// No dependencies.
`timescale 1ns / 1ps

package qsed_pkg;

  // Parser modes, one-hot
  typedef enum logic [7:0] {
    MODE_START   = 8'b0000_0001,
    MODE_BETWEEN = 8'b0000_0010,
    MODE_STRING  = 8'b0000_0100,
    MODE_ESCAPE  = 8'b0000_1000,
    MODE_OCTAL   = 8'b0001_0000,
    MODE_HEXHEAD = 8'b0010_0000,
    MODE_HEX     = 8'b0100_0000,
    MODE_SKIP    = 8'b1000_0000
  } mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // Characters with a meaning to the parser
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChX     = 8'h78;

  // One result request
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data;
    logic              last;
  } result_t;

  // Up to two results caused by one input byte
  typedef struct packed {
    result_t     res1;
    result_t     res0;
    logic [1:0]  count;
  } result_pair_t;

  // Octal digit test
  function automatic logic is_octal(input logic [7:0] c);
    is_octal = (c[7:3] == 5'b00110);
  endfunction

  // Hex digit value; bit 4 flags a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    hex_value = v;
  endfunction

  // Simple escape letters; bit 8 flags a known letter
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] v;
    case (c)
      8'h6E:   v = {1'b1, 8'd10};  // n
      8'h74:   v = {1'b1, 8'd9};   // t
      8'h62:   v = {1'b1, 8'd8};   // b
      8'h72:   v = {1'b1, 8'd13};  // r
      8'h66:   v = {1'b1, 8'd12};  // f
      8'h76:   v = {1'b1, 8'd11};  // v
      8'h61:   v = {1'b1, 8'd7};   // a
      ChBsl:   v = {1'b1, ChBsl};
      ChQuote: v = {1'b1, ChQuote};
      default: v = 9'd0;
    endcase
    simple_escape = v;
  endfunction

endpackage

>>> src/quoted_string_escape_decoder_unit.sv
// Top level of the quoted string escape decoder: input register, parser, result register.
// Depends on qsed_pkg, qsed_parse, qsed_out and the assertion macro header.
//
//  channel | direction | data                    | side band
//  s_axis  | in        | tdata[7:0] text_byte    | -
//  m_axis  | out       | tdata[7:0] decoded_byte | tuser[1:0] = result_kind,
//          |           |                         | tlast = last_of_run
//
// One input byte per cycle unless stalled; it passes the input and result registers.
// A byte that causes two results occupies the result register until both are handed out.
// Bytes that cause no result pass through without any output cycle.
// Reset returns the parser to expecting an opening quote and empties both registers.
// Output stalls back up through the result register into the input register.
`timescale 1ns / 1ps
`include "quoted_string_escape_decoder_unit_assert.svh"

module quoted_string_escape_decoder_unit
  import qsed_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] text_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [7:0] decoded_byte
  output logic [KindW-1:0]    m_axis_tuser_o,   // [1:0] result_kind
  output logic                m_axis_tlast_o
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  logic         s_accept;
  logic         advance;
  logic         out_free;
  result_pair_t pair;
  result_t      res;

  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  qsed_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .byte_i (in_byte_q),
    .pair_o (pair)
  );

  qsed_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .pair_i  (pair),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  // Pack the result request
  assign m_axis_tdata_o = res.data;
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

  // Completion and error results always end the results of their byte and carry no byte
  `QSED_ASSERT_IMPL(a_status_last, clk_i, rst_ni, m_axis_tvalid_o && res.kind != KIND_BYTE, m_axis_tlast_o && res.data == 8'd0, "status result without tlast or with data")
  // A result kind is never the unused code
  `QSED_ASSERT_IMPL(a_kind_known, clk_i, rst_ni, m_axis_tvalid_o, res.kind == KIND_BYTE || res.kind == KIND_DONE || res.kind == KIND_ERROR, "unknown result kind")
  // A stalled input byte stays in the input register
  `QSED_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !out_free, in_valid_q && $stable(in_byte_q), "input byte lost while stalled")

endmodule

>>> src/qsed_parse.sv
// Parser state and next-state logic: one input byte per enabled cycle.
// Depends on qsed_pkg.
`timescale 1ns / 1ps

module qsed_parse
  import qsed_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [7:0]   byte_i,
  output result_pair_t pair_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] val_q, val_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    logic [4:0]   hv;
    logic [8:0]   se;
    logic [1:0]   cnt_inc;
    logic [7:0]   oct_val;
    logic [7:0]   hex_val;
    logic [7:0]   str_c;
    logic         str_pending;
    result_t      r [2];
    logic [1:0]   n;

    mode_d      = mode_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    hv          = hex_value(byte_i);
    se          = simple_escape(byte_i);
    cnt_inc     = cnt_q + 2'd1;
    oct_val     = {val_q[4:0], byte_i[2:0]};
    hex_val     = {val_q[3:0], hv[3:0]};
    str_c       = byte_i;
    str_pending = 1'b0;
    n           = 2'd0;
    r[0]        = '{kind: KIND_BYTE, data: 8'd0, last: 1'b0};
    r[1]        = '{kind: KIND_BYTE, data: 8'd0, last: 1'b0};

    unique case (mode_q)
      MODE_START: begin
        if (byte_i == ChQuote) begin
          mode_d = MODE_STRING;
        end else begin
          r[0]   = '{kind: KIND_ERROR, data: 8'd0, last: 1'b0};
          n      = 2'd1;
          mode_d = (byte_i == ChNul) ? MODE_START : MODE_SKIP;
        end
      end
      MODE_BETWEEN: begin
        if (byte_i == ChQuote) begin
          mode_d = MODE_STRING;
        end else if (byte_i == ChSpace || byte_i == ChTab) begin
          mode_d = MODE_BETWEEN;
        end else if (byte_i == ChNul) begin
          r[0]   = '{kind: KIND_DONE, data: 8'd0, last: 1'b0};
          n      = 2'd1;
          mode_d = MODE_START;
        end else begin
          r[0]   = '{kind: KIND_ERROR, data: 8'd0, last: 1'b0};
          n      = 2'd1;
          mode_d = MODE_SKIP;
        end
      end
      MODE_STRING: begin
        str_pending = 1'b1;
      end
      MODE_ESCAPE: begin
        if (se[8]) begin
          r[0]   = '{kind: KIND_BYTE, data: se[7:0], last: 1'b0};
          n      = 2'd1;
          mode_d = MODE_STRING;
        end else if (byte_i == ChX) begin
          mode_d = MODE_HEXHEAD;
        end else if (is_octal(byte_i)) begin
          val_d  = {5'd0, byte_i[2:0]};
          cnt_d  = 2'd1;
          mode_d = MODE_OCTAL;
        end else begin
          r[0]   = '{kind: KIND_ERROR, data: 8'd0, last: 1'b0};
          n      = 2'd1;
          mode_d = (byte_i == ChNul) ? MODE_START : MODE_SKIP;
        end
      end
      MODE_OCTAL: begin
        if (is_octal(byte_i)) begin
          val_d = oct_val;
          cnt_d = cnt_inc;
          if (cnt_inc == 2'd3) begin
            r[0]   = '{kind: KIND_BYTE, data: oct_val, last: 1'b0};
            n      = 2'd1;
            mode_d = MODE_STRING;
          end
        end else begin
          // Flush the value, then treat the byte as a string character
          r[0]        = '{kind: KIND_BYTE, data: val_q, last: 1'b0};
          n           = 2'd1;
          str_pending = 1'b1;
        end
      end
      MODE_HEXHEAD: begin
        if (hv[4]) begin
          val_d  = {4'd0, hv[3:0]};
          cnt_d  = 2'd1;
          mode_d = MODE_HEX;
        end else begin
          r[0]   = '{kind: KIND_ERROR, data: 8'd0, last: 1'b0};
          n      = 2'd1;
          mode_d = (byte_i == ChNul) ? MODE_START : MODE_SKIP;
        end
      end
      MODE_HEX: begin
        if (hv[4]) begin
          val_d  = hex_val;
          cnt_d  = 2'd2;
          r[0]   = '{kind: KIND_BYTE, data: hex_val, last: 1'b0};
          n      = 2'd1;
          mode_d = MODE_STRING;
        end else begin
          r[0]        = '{kind: KIND_BYTE, data: val_q, last: 1'b0};
          n           = 2'd1;
          str_pending = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (byte_i == ChNul) begin
          mode_d = MODE_START;
        end
      end
      default: begin
        mode_d = MODE_START;
      end
    endcase

    // Ordinary string character, possibly after a flushed escape value
    if (str_pending) begin
      if (str_c == ChNul) begin
        r[n[0]] = '{kind: KIND_ERROR, data: 8'd0, last: 1'b0};
        n       = n + 2'd1;
        mode_d  = MODE_START;
      end else if (str_c == ChQuote) begin
        mode_d = MODE_BETWEEN;
      end else if (str_c == ChBsl) begin
        mode_d = MODE_ESCAPE;
      end else begin
        r[n[0]] = '{kind: KIND_BYTE, data: str_c, last: 1'b0};
        n       = n + 2'd1;
        mode_d  = MODE_STRING;
      end
    end

    // Mark the final result of this byte
    if (n == 2'd1) begin
      r[0].last = 1'b1;
    end else if (n == 2'd2) begin
      r[1].last = 1'b1;
    end

    pair_o.res0  = r[0];
    pair_o.res1  = r[1];
    pair_o.count = n;
  end

  // Advance parser state on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      val_q  <= 8'd0;
      cnt_q  <= 2'd0;
    end else if (en_i) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> src/qsed_out.sv
// Result register: holds up to two results of one byte and hands them out in order.
// Depends on qsed_pkg.
`timescale 1ns / 1ps

module qsed_out
  import qsed_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  result_pair_t pair_i,
  output logic         free_o,
  output logic         valid_o,
  input  logic         ready_i,
  output result_t      res_o
);

  result_t    res0_q, res1_q;
  logic [1:0] n_q, n_d;
  logic       idx_q, idx_d;
  logic       fire;
  logic       last_fire;

  assign valid_o   = (n_q != 2'd0);
  assign res_o     = idx_q ? res1_q : res0_q;
  assign fire      = valid_o && ready_i;
  assign last_fire = fire && (idx_q || n_q == 2'd1);
  assign free_o    = !valid_o || last_fire;

  // Load a new pair, step to the second result, or drain
  always_comb begin
    n_d   = n_q;
    idx_d = idx_q;
    if (load_i) begin
      n_d   = pair_i.count;
      idx_d = 1'b0;
    end else if (last_fire) begin
      n_d   = 2'd0;
      idx_d = 1'b0;
    end else if (fire) begin
      idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= 2'd0;
      idx_q <= 1'b0;
    end else begin
      n_q   <= n_d;
      idx_q <= idx_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res0_q <= pair_i.res0;
      res1_q <= pair_i.res1;
    end
  end

endmodule
